/* rtl/core/tftp_pkg.sv */
`timescale 1ns / 1ps

package tftp_pkg;

    // Field widths
    localparam int CMD_W   = 2;
    localparam int OP_W    = 8;
    localparam int BLK_W   = 16;
    localparam int LEN_W   = 10;
    localparam int KIND_W  = 3;
    localparam int STAT_W  = 2;
    localparam int ERR_W   = 8;
    localparam int RETRY_W = 8;

    // Full-size block; a shorter block ends the transfer
    localparam logic [LEN_W-1:0] BLOCK_BYTES = LEN_W'(512);

    localparam logic [RETRY_W-1:0] RETRY_LIMIT_RESET = RETRY_W'(5);

    // Event codes
    localparam logic [CMD_W-1:0] CMD_UPLOAD   = CMD_W'(0);
    localparam logic [CMD_W-1:0] CMD_DOWNLOAD = CMD_W'(1);
    localparam logic [CMD_W-1:0] CMD_PACKET   = CMD_W'(2);
    localparam logic [CMD_W-1:0] CMD_TIMEOUT  = CMD_W'(3);

    // Received opcodes
    localparam logic [OP_W-1:0] OP_DATA  = OP_W'(3);
    localparam logic [OP_W-1:0] OP_ACK   = OP_W'(4);
    localparam logic [OP_W-1:0] OP_ERROR = OP_W'(5);

    // Packet to send
    localparam logic [KIND_W-1:0] TX_NONE = KIND_W'(0);
    localparam logic [KIND_W-1:0] TX_WRQ  = KIND_W'(1);
    localparam logic [KIND_W-1:0] TX_RRQ  = KIND_W'(2);
    localparam logic [KIND_W-1:0] TX_DATA = KIND_W'(3);
    localparam logic [KIND_W-1:0] TX_ACK  = KIND_W'(4);

    // Completion status
    localparam logic [STAT_W-1:0] ST_BUSY    = STAT_W'(0);
    localparam logic [STAT_W-1:0] ST_OK      = STAT_W'(1);
    localparam logic [STAT_W-1:0] ST_TIMEOUT = STAT_W'(2);
    localparam logic [STAT_W-1:0] ST_ERROR   = STAT_W'(3);

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [OP_W-1:0]  rx_opcode;
        logic [BLK_W-1:0] rx_block;
        logic [LEN_W-1:0] rx_payload_len;
        logic [LEN_W-1:0] chunk_len;
    } req_t;

    typedef struct packed {
        logic [KIND_W-1:0] tx_kind;
        logic [BLK_W-1:0]  tx_block;
        logic [LEN_W-1:0]  tx_len;
        logic [LEN_W-1:0]  store_len;
        logic [STAT_W-1:0] status;
        logic [ERR_W-1:0]  err_code;
    } rsp_t;

    // Saturate a length at one full block
    function automatic logic [LEN_W-1:0] clip_len(input logic [LEN_W-1:0] len);
        clip_len = (len > BLOCK_BYTES) ? BLOCK_BYTES : len;
    endfunction

endpackage

/* rtl/core/tftp_transfer_controller_unit.sv */
`timescale 1ns / 1ps

// Lockstep transfer control for a TFTP client. Each transfer on req is one
// event (start upload, start download, received packet header, or reply
// timeout) and produces exactly one transfer on rsp naming the packet to send
// next, the payload bytes to store and the completion status. The block takes
// one event per clock cycle while rsp_ready does not stall the output: an
// event is held in the input register, passes the single next-state pass of
// the transfer state machine, and its result lands in the output register,
// which drives rsp_valid. The output register lets a new event enter while a
// finished result still waits on rsp_ready. retry_limit (reset 5) is written
// through cfg and should change only while no event is in flight.
module tftp_transfer_controller_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  tftp_pkg::req_t                req,
    output logic                          rsp_valid,
    input  logic                          rsp_ready,
    output tftp_pkg::rsp_t                rsp,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [tftp_pkg::RETRY_W-1:0]  cfg_data
);
    import tftp_pkg::*;

    req_t               req_reg;
    logic               req_vld_reg;
    rsp_t               rsp_reg;
    logic               rsp_vld_reg;
    logic [RETRY_W-1:0] retry_limit_reg;

    rsp_t               result;
    logic               take;
    logic               step;

    // The output slot is free when empty or being drained this cycle
    assign take      = !rsp_vld_reg || rsp_ready;
    // Advance the held event through the state machine
    assign step      = req_vld_reg && take;
    // Accept a new event whenever the input slot empties this cycle
    assign req_ready = !req_vld_reg || take;
    assign cfg_ready = 1'b1;

    assign rsp_valid = rsp_vld_reg;
    assign rsp       = rsp_reg;

    tftp_fsm u_fsm (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .item        (req_reg),
        .retry_limit (retry_limit_reg),
        .result      (result)
    );

    // Control: slot valid flags and the retry limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_vld_reg     <= 1'b0;
            rsp_vld_reg     <= 1'b0;
            retry_limit_reg <= RETRY_LIMIT_RESET;
        end
        else
        begin
            if (req_ready)
            begin
                req_vld_reg <= req_valid;
            end
            if (take)
            begin
                rsp_vld_reg <= req_vld_reg;
            end
            if (cfg_valid && cfg_ready)
            begin
                retry_limit_reg <= cfg_data;
            end
        end
    end

    // Payload: capture the event and hold the result until its transfer
    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            req_reg <= req;
        end
        if (step)
        begin
            rsp_reg <= result;
        end
    end

endmodule

/* rtl/core/tftp_fsm.sv */
`timescale 1ns / 1ps

module tftp_fsm (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  step,
    input  tftp_pkg::req_t                        item,
    input  logic [tftp_pkg::RETRY_W-1:0]          retry_limit,
    output tftp_pkg::rsp_t                        result
);
    import tftp_pkg::*;

    localparam logic [2:0] PH_IDLE     = 3'd0;
    localparam logic [2:0] PH_WRQ      = 3'd1;
    localparam logic [2:0] PH_UP_DATA  = 3'd2;
    localparam logic [2:0] PH_DL_FIRST = 3'd3;
    localparam logic [2:0] PH_DL       = 3'd4;

    logic [2:0]         phase_reg, phase_next;
    logic [BLK_W-1:0]   block_number_reg, block_number_next;
    logic [RETRY_W-1:0] retry_count_reg, retry_count_next;
    logic [LEN_W-1:0]   current_len_reg, current_len_next;
    logic               final_block_reg, final_block_next;

    logic [LEN_W-1:0]   plen;
    logic [LEN_W-1:0]   chunk;
    logic               exhausted;
    logic               is_start;
    logic               is_packet;
    logic               err_pkt;
    logic               good_ack;
    logic [BLK_W-1:0]   next_block;

    assign plen       = clip_len(item.rx_payload_len);
    assign chunk      = clip_len(item.chunk_len);
    assign exhausted  = retry_count_reg >= retry_limit;
    assign is_start   = (item.cmd == CMD_UPLOAD) || (item.cmd == CMD_DOWNLOAD);
    assign is_packet  = item.cmd == CMD_PACKET;
    assign err_pkt    = is_packet && (item.rx_opcode == OP_ERROR);
    assign good_ack   = is_packet && (item.rx_opcode == OP_ACK)
                        && (item.rx_block == block_number_reg);
    assign next_block = block_number_reg + BLK_W'(1);

    always_comb
    begin
        phase_next        = phase_reg;
        block_number_next = block_number_reg;
        retry_count_next  = retry_count_reg;
        current_len_next  = current_len_reg;
        final_block_next  = final_block_reg;
        result            = '0;

        unique case (phase_reg) inside
            PH_IDLE:
            begin
                if (item.cmd == CMD_UPLOAD)
                begin
                    phase_next        = PH_WRQ;
                    block_number_next = '0;
                    retry_count_next  = RETRY_W'(1);
                    current_len_next  = '0;
                    final_block_next  = 1'b0;
                    result.tx_kind    = TX_WRQ;
                end
                else if (item.cmd == CMD_DOWNLOAD)
                begin
                    phase_next        = PH_DL_FIRST;
                    block_number_next = BLK_W'(1);
                    retry_count_next  = RETRY_W'(1);
                    current_len_next  = '0;
                    final_block_next  = 1'b0;
                    result.tx_kind    = TX_RRQ;
                end
            end

            PH_WRQ, PH_UP_DATA:
            begin
                if (is_start)
                begin
                end
                else if (err_pkt)
                begin
                    phase_next      = PH_IDLE;
                    result.status   = ST_ERROR;
                    result.err_code = item.rx_block[ERR_W-1:0];
                end
                else if (good_ack)
                begin
                    if ((phase_reg == PH_UP_DATA) && final_block_reg)
                    begin
                        phase_next    = PH_IDLE;
                        result.status = ST_OK;
                    end
                    else
                    begin
                        // send the next DATA block
                        phase_next        = PH_UP_DATA;
                        block_number_next = (phase_reg == PH_WRQ) ? BLK_W'(1) : next_block;
                        current_len_next  = chunk;
                        final_block_next  = chunk < BLOCK_BYTES;
                        retry_count_next  = RETRY_W'(1);
                        result.tx_kind    = TX_DATA;
                        result.tx_block   = block_number_next;
                        result.tx_len     = chunk;
                    end
                end
                else if (exhausted)
                begin
                    phase_next    = PH_IDLE;
                    result.status = ST_TIMEOUT;
                end
                else
                begin
                    // resend the outstanding packet
                    retry_count_next = retry_count_reg + RETRY_W'(1);
                    if (phase_reg == PH_WRQ)
                    begin
                        result.tx_kind = TX_WRQ;
                    end
                    else
                    begin
                        result.tx_kind  = TX_DATA;
                        result.tx_block = block_number_reg;
                        result.tx_len   = current_len_reg;
                    end
                end
            end

            PH_DL_FIRST, PH_DL:
            begin
                if (is_start)
                begin
                end
                else if (err_pkt)
                begin
                    phase_next      = PH_IDLE;
                    result.status   = ST_ERROR;
                    result.err_code = item.rx_block[ERR_W-1:0];
                end
                else if (is_packet)
                begin
                    if ((item.rx_opcode == OP_DATA) && (item.rx_block == block_number_reg))
                    begin
                        result.tx_kind   = TX_ACK;
                        result.tx_block  = block_number_reg;
                        result.store_len = plen;
                        if (plen < BLOCK_BYTES)
                        begin
                            phase_next    = PH_IDLE;
                            result.status = ST_OK;
                        end
                        else
                        begin
                            phase_next        = PH_DL;
                            block_number_next = next_block;
                            retry_count_next  = RETRY_W'(1);
                        end
                    end
                end
                else if ((phase_reg == PH_DL_FIRST) || exhausted)
                begin
                    phase_next    = PH_IDLE;
                    result.status = ST_TIMEOUT;
                end
                else
                begin
                    // re-acknowledge the previous block
                    retry_count_next = retry_count_reg + RETRY_W'(1);
                    result.tx_kind   = TX_ACK;
                    result.tx_block  = block_number_reg - BLK_W'(1);
                end
            end

            default:
            begin
                if (!is_start)
                begin
                    phase_next = PH_IDLE;
                    if (err_pkt)
                    begin
                        result.status   = ST_ERROR;
                        result.err_code = item.rx_block[ERR_W-1:0];
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            block_number_reg <= '0;
            retry_count_reg  <= '0;
            current_len_reg  <= '0;
            final_block_reg  <= 1'b0;
        end
        else if (step)
        begin
            phase_reg        <= phase_next;
            block_number_reg <= block_number_next;
            retry_count_reg  <= retry_count_next;
            current_len_reg  <= current_len_next;
            final_block_reg  <= final_block_next;
        end
    end

    a_busy_has_attempt: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_IDLE) |-> (retry_count_reg != '0))
        else $error("busy phase with no attempt counted");

    a_done_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (step && (result.status != ST_BUSY)) |=> (phase_reg == PH_IDLE))
        else $error("completion status without return to idle");

    a_hold_without_step: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> ($stable(phase_reg) && $stable(block_number_reg)
                   && $stable(retry_count_reg)))
        else $error("state moved without an item");

    a_wrq_block_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_WRQ) |-> (block_number_reg == '0))
        else $error("WRQ phase with nonzero block number");

    a_first_dl_block_one: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DL_FIRST) |-> (block_number_reg == BLK_W'(1)))
        else $error("first download phase not waiting on block one");

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps

import tftp_pkg::*;

typedef enum logic [2:0] {
    PH_IDLE,
    PH_WRQ,
    PH_UP_DATA,
    PH_DL_FIRST,
    PH_DL
} xfer_phase_t;

class transfer_tracker;
    logic [RETRY_W-1:0] retry_limit;
    xfer_phase_t        phase;
    logic [BLK_W-1:0]   block_number;
    logic [RETRY_W-1:0] retry_count;
    logic [LEN_W-1:0]   current_len;
    logic               final_block;
    rsp_t               pending_replies[$];
    int                 failures;

    function new();
        retry_limit  = RETRY_LIMIT_RESET;
        phase        = PH_IDLE;
        block_number = '0;
        retry_count  = '0;
        current_len  = '0;
        final_block  = 1'b0;
        failures     = 0;
    endfunction

    function rsp_t next_block(logic [LEN_W-1:0] chunk);
        rsp_t r;
        r            = '0;
        current_len  = chunk;
        final_block  = chunk < BLOCK_BYTES;
        retry_count  = RETRY_W'(1);
        r.tx_kind    = TX_DATA;
        r.tx_block   = block_number;
        r.tx_len     = chunk;
        return r;
    endfunction

    function void note_event(req_t ev);
        rsp_t             r;
        logic [LEN_W-1:0] plen;
        logic [LEN_W-1:0] chunk;
        logic             exhausted;
        logic             good;
        r         = '0;
        plen      = (ev.rx_payload_len > BLOCK_BYTES) ? BLOCK_BYTES : ev.rx_payload_len;
        chunk     = (ev.chunk_len > BLOCK_BYTES) ? BLOCK_BYTES : ev.chunk_len;
        exhausted = retry_count >= retry_limit;
        if (phase == PH_IDLE) begin
            if (ev.cmd == CMD_UPLOAD) begin
                phase        = PH_WRQ;
                block_number = '0;
                retry_count  = RETRY_W'(1);
                current_len  = '0;
                final_block  = 1'b0;
                r.tx_kind    = TX_WRQ;
            end else if (ev.cmd == CMD_DOWNLOAD) begin
                phase        = PH_DL_FIRST;
                block_number = BLK_W'(1);
                retry_count  = RETRY_W'(1);
                current_len  = '0;
                final_block  = 1'b0;
                r.tx_kind    = TX_RRQ;
            end
        end else if (ev.cmd == CMD_UPLOAD || ev.cmd == CMD_DOWNLOAD) begin
            // start while busy: drop it
        end else if (ev.cmd == CMD_PACKET && ev.rx_opcode == OP_ERROR) begin
            phase      = PH_IDLE;
            r.status   = ST_ERROR;
            r.err_code = ev.rx_block[ERR_W-1:0];
        end else if (phase == PH_WRQ || phase == PH_UP_DATA) begin
            good = ev.cmd == CMD_PACKET && ev.rx_opcode == OP_ACK
                   && ev.rx_block == block_number;
            if (good && phase == PH_WRQ) begin
                phase        = PH_UP_DATA;
                block_number = BLK_W'(1);
                r            = next_block(chunk);
            end else if (good && final_block) begin
                phase    = PH_IDLE;
                r.status = ST_OK;
            end else if (good) begin
                block_number = block_number + 1'b1;
                r            = next_block(chunk);
            end else if (exhausted) begin
                phase    = PH_IDLE;
                r.status = ST_TIMEOUT;
            end else begin
                retry_count++;
                if (phase == PH_WRQ) begin
                    r.tx_kind = TX_WRQ;
                end else begin
                    r.tx_kind  = TX_DATA;
                    r.tx_block = block_number;
                    r.tx_len   = current_len;
                end
            end
        end else if (ev.cmd == CMD_PACKET) begin
            if (ev.rx_opcode == OP_DATA && ev.rx_block == block_number) begin
                r.tx_kind   = TX_ACK;
                r.tx_block  = block_number;
                r.store_len = plen;
                if (plen < BLOCK_BYTES) begin
                    phase    = PH_IDLE;
                    r.status = ST_OK;
                end else begin
                    phase        = PH_DL;
                    block_number = block_number + 1'b1;
                    retry_count  = RETRY_W'(1);
                end
            end
        end else if (phase == PH_DL_FIRST || exhausted) begin
            phase    = PH_IDLE;
            r.status = ST_TIMEOUT;
        end else begin
            retry_count++;
            r.tx_kind  = TX_ACK;
            r.tx_block = block_number - 1'b1;
        end
        pending_replies.push_back(r);
    endfunction

    function void flag(string field, logic [31:0] want, logic [31:0] got);
        failures++;
        if (failures <= 100)
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
    endfunction

    function void check_reply(rsp_t got);
        rsp_t want;
        if (pending_replies.size() == 0) begin
            failures++;
            if (failures <= 100)
                $display("%0t: reply with nothing outstanding: expected none, actual %h",
                         $time, got);
            return;
        end
        want = pending_replies.pop_front();
        if (got.tx_kind !== want.tx_kind)     flag("tx_kind", want.tx_kind, got.tx_kind);
        if (got.tx_block !== want.tx_block)   flag("tx_block", want.tx_block, got.tx_block);
        if (got.tx_len !== want.tx_len)       flag("tx_len", want.tx_len, got.tx_len);
        if (got.store_len !== want.store_len) flag("store_len", want.store_len, got.store_len);
        if (got.status !== want.status)       flag("status", want.status, got.status);
        if (got.err_code !== want.err_code)   flag("err_code", want.err_code, got.err_code);
    endfunction
endclass

module testbench;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               req_valid;
    logic               req_ready;
    req_t               req;
    logic               rsp_valid;
    logic               rsp_ready;
    rsp_t               rsp;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [RETRY_W-1:0] cfg_data;

    transfer_tracker ledger = new();

    // When set, both sides run back to back with no idle cycles
    bit steady = 1'b0;
    // Remaining events of a run of timeouts and bad replies
    int storm_left = 0;

    tftp_transfer_controller_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Hard stop in case a handshake never completes
    initial
    begin
        #20_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // Check every reply transfer against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
            ledger.check_reply(rsp);
    end

    function automatic int pause_draw();
        return steady ? 0 : $urandom_range(0, 13);
    endfunction

    function automatic req_t build_event(logic [CMD_W-1:0] cmd, logic [OP_W-1:0] op,
                                         logic [BLK_W-1:0] blk, logic [LEN_W-1:0] plen,
                                         logic [LEN_W-1:0] chunk);
        req_t ev;
        ev.cmd            = cmd;
        ev.rx_opcode      = op;
        ev.rx_block       = blk;
        ev.rx_payload_len = plen;
        ev.chunk_len      = chunk;
        return ev;
    endfunction

    // Mostly full blocks so transfers run on; short and oversized ones now and then
    function automatic logic [LEN_W-1:0] draw_length();
        case ($urandom_range(0, 9))
            6, 7:    return LEN_W'($urandom_range(0, 511));
            8:       return LEN_W'($urandom_range(513, 1023));
            9:       return $urandom_range(0, 1) ? LEN_W'(1023) : LEN_W'(0);
            default: return BLOCK_BYTES;
        endcase
    endfunction

    // Build the next event from the tracked protocol state: mostly the reply a
    // healthy peer would give, the rest timeouts, wrong replies and aborts
    function automatic req_t shaped_event();
        req_t             ev;
        int               pick;
        logic [OP_W-1:0]  good_op;
        ev.cmd            = CMD_PACKET;
        ev.rx_opcode      = OP_W'($urandom);
        ev.rx_block       = BLK_W'($urandom);
        ev.rx_payload_len = LEN_W'($urandom);
        ev.chunk_len      = LEN_W'($urandom);
        pick              = $urandom_range(0, 99);
        good_op = (ledger.phase == PH_WRQ || ledger.phase == PH_UP_DATA) ? OP_ACK : OP_DATA;
        if (ledger.phase == PH_IDLE) begin
            if (pick < 85)
                ev.cmd = $urandom_range(0, 1) ? CMD_DOWNLOAD : CMD_UPLOAD;
            else
                ev.cmd = $urandom_range(0, 1) ? CMD_TIMEOUT : CMD_PACKET;
        end else if (storm_left > 0) begin
            storm_left--;
            ev.cmd = ($urandom_range(0, 3) == 0) ? CMD_PACKET : CMD_TIMEOUT;
            if (ev.rx_opcode == OP_ERROR)
                ev.rx_opcode = good_op;
            ev.rx_block = ledger.block_number + BLK_W'($urandom_range(1, 65535));
        end else if (pick < 70) begin
            ev.rx_opcode      = good_op;
            ev.rx_block       = ledger.block_number;
            ev.rx_payload_len = draw_length();
            ev.chunk_len      = draw_length();
        end else if (pick < 80) begin
            ev.cmd = CMD_TIMEOUT;
        end else if (pick < 86) begin
            ev.rx_opcode = good_op;
            ev.rx_block  = ledger.block_number + BLK_W'($urandom_range(1, 65535));
        end else if (pick < 91) begin
            ev.rx_block = ledger.block_number;
        end else if (pick < 95) begin
            ev.rx_opcode = OP_ERROR;
        end else if (pick < 98) begin
            ev.cmd = $urandom_range(0, 1) ? CMD_DOWNLOAD : CMD_UPLOAD;
        end else begin
            storm_left = $urandom_range(2, 12);
            ev.cmd     = CMD_TIMEOUT;
        end
        return ev;
    endfunction

    // Hold the event until the block takes it, then record the transfer.
    // Returns at the accepting edge so the next call can keep valid high.
    task automatic send_event(input req_t ev);
        int gap;
        gap = pause_draw();
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= ev;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
        ledger.note_event(ev);
    endtask

    // Write retry_limit once every outstanding reply has come back
    task automatic write_retry_limit(input logic [RETRY_W-1:0] value);
        req_valid <= 1'b0;
        while (ledger.pending_replies.size() != 0) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid          <= 1'b0;
        ledger.retry_limit = value;
    endtask

    // Abort whatever runs, start an upload and time out until it gives up
    task automatic exhaust_retries();
        int tries;
        tries = (ledger.retry_limit == 0) ? 1 : ledger.retry_limit;
        if (ledger.phase != PH_IDLE)
            send_event(build_event(CMD_PACKET, OP_ERROR, BLK_W'($urandom), '0, '0));
        send_event(build_event(CMD_UPLOAD, '0, '0, '0, '0));
        repeat (tries) send_event(build_event(CMD_TIMEOUT, '0, '0, '0, '0));
    endtask

    // Receive side: stall a random number of cycles before each reply
    initial
    begin : reply_sink
        int stall;
        rsp_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            stall = pause_draw();
            if (stall > 0) begin
                rsp_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ready <= 1'b1;
            @(posedge clk);
            while (!rsp_valid) @(posedge clk);
        end
    end

    initial
    begin : stimulus
        logic [RETRY_W-1:0] limits [6];
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        limits    = '{8'd1, 8'd255, 8'd0, 8'd3, 8'd5, 8'd5};
        limits[4] = RETRY_W'($urandom_range(2, 30));
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Idle events: packets and timeouts give no packet
        send_event(build_event(CMD_PACKET, OP_ACK, '0, '0, '0));
        send_event(build_event(CMD_TIMEOUT, '0, '0, '0, '0));
        // Upload: ignored start, wrong ACK, oversized chunk, resend, empty last block
        send_event(build_event(CMD_UPLOAD, '0, '0, '0, '0));
        send_event(build_event(CMD_DOWNLOAD, '0, '0, '0, '0));
        send_event(build_event(CMD_PACKET, OP_ACK, 16'hFFFF, '0, '0));
        send_event(build_event(CMD_PACKET, OP_ACK, '0, '0, LEN_W'(1023)));
        send_event(build_event(CMD_PACKET, OP_ACK, BLK_W'(1), '0, BLOCK_BYTES));
        send_event(build_event(CMD_TIMEOUT, '0, '0, '0, '0));
        send_event(build_event(CMD_PACKET, OP_ACK, BLK_W'(2), '0, '0));
        send_event(build_event(CMD_PACKET, OP_ACK, BLK_W'(3), '0, '0));
        // Download: timeout before the first block fails at once
        send_event(build_event(CMD_DOWNLOAD, '0, '0, '0, '0));
        send_event(build_event(CMD_TIMEOUT, '0, '0, '0, '0));
        // Download: oversized payload, ignored wrong replies, re-ack, short end
        send_event(build_event(CMD_DOWNLOAD, '0, '0, '0, '0));
        send_event(build_event(CMD_PACKET, OP_DATA, BLK_W'(1), LEN_W'(1023), '0));
        send_event(build_event(CMD_PACKET, 8'hFF, BLK_W'(2), '0, '0));
        send_event(build_event(CMD_PACKET, OP_DATA, BLK_W'(7), BLOCK_BYTES, '0));
        send_event(build_event(CMD_TIMEOUT, '0, '0, '0, '0));
        send_event(build_event(CMD_PACKET, OP_DATA, BLK_W'(2), LEN_W'(511), '0));
        // ERROR aborts a WRQ wait and a running download; ignored while idle
        send_event(build_event(CMD_UPLOAD, '0, '0, '0, '0));
        send_event(build_event(CMD_PACKET, OP_ERROR, 16'hABCD, '0, '0));
        send_event(build_event(CMD_DOWNLOAD, '0, '0, '0, '0));
        send_event(build_event(CMD_PACKET, OP_DATA, BLK_W'(1), BLOCK_BYTES, '0));
        send_event(build_event(CMD_PACKET, OP_ERROR, 16'hFFFF, '0, '0));
        send_event(build_event(CMD_PACKET, OP_ERROR, 16'h1234, '0, '0));
        send_event(build_event(CMD_UPLOAD, '0, '0, '0, '0));
        send_event(build_event(CMD_PACKET, OP_ACK, '0, '0, LEN_W'(600)));

        // One phase per retry limit: a full retry run, then shaped random traffic
        foreach (limits[k]) begin
            write_retry_limit(limits[k]);
            exhaust_retries();
            for (int i = 0; i < 80; i++) begin
                if ($urandom_range(0, 39) == 0)
                    steady = !steady;
                send_event(shaped_event());
            end
            steady = 1'b0;
        end

        req_valid <= 1'b0;
        while (ledger.pending_replies.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (ledger.failures == 0 && ledger.pending_replies.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
